// File: design/lcrs_pkg.sv
package lcrs_pkg;

  // default fraction bits of sine and cosine
  localparam int FRAC_BITS_DEF = 14;

  localparam int PIX_W  = 32;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int IDX_W  = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_MODE       = 3'd0,
    REG_SAT_GAIN   = 3'd1,
    REG_ANGLE      = 3'd2,
    REG_WHITE_V    = 3'd3,
    REG_WHITE_U    = 3'd4
  } reg_idx_t;

  localparam logic               MODE_RST    = 1'b0;
  localparam logic signed [15:0] GAIN_RST    = 16'sd256;
  localparam logic [15:0]        ANGLE_RST   = 16'd0;
  localparam logic [7:0]         WHITE_V_RST = 8'd128;
  localparam logic [7:0]         WHITE_U_RST = 8'd128;

  localparam logic MODE_SCALE  = 1'b0;
  localparam logic MODE_ROTATE = 1'b1;

endpackage

// File: design/luv_chroma_rotate_saturate_top.sv
// LUV chroma adjust. One packed pixel (half-float L in 31:16, u in 15:8, v in 7:0) is taken
// on each clock where start is high; busy stays low, so a pixel may be issued every cycle.
// The adjusted pixel appears on out_pixel_out five cycles later, marked by a one-cycle
// out_valid strobe, and must be taken then: the output side has no way to hold results off.
// The five-stage pipeline (angle segment select, edge interpolation and gain products,
// sine/cosine, rotation products, sum with clamp) sets that latency; throughput is one
// pixel per clock. Mode 0 scales the chroma offset from the white point by a signed Q8.8
// gain, mode 1 rotates it by a Q0.16 angle using triangle-interpolated sine and cosine.
// Registers sit on the APB port at byte offsets 0 (mode), 4 (gain), 8 (angle), 12 (white v)
// and 16 (white u); write them only while no pixel is in flight.
module luv_chroma_rotate_saturate_top #(
  parameter int FRAC_BITS = lcrs_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [lcrs_pkg::PIX_W-1:0]  in_pixel_in,
  output logic                        out_valid,
  output logic [lcrs_pkg::PIX_W-1:0]  out_pixel_out,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lcrs_pkg::ADDR_W-1:0] paddr,
  input  logic [lcrs_pkg::DATA_W-1:0] pwdata,
  output logic [lcrs_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  localparam int TW  = FRAC_BITS + 2;   // sine / cosine
  localparam int DW  = FRAC_BITS + 2;   // vertex difference
  localparam int MW  = 17;              // edge position, signed
  localparam int PCW = DW + MW;         // interpolation product
  localparam int GW  = 25;              // offset times gain
  localparam int PW  = TW + 9;          // rotation product
  localparam int SW  = PW + 1;          // rotation sum
  localparam int OW  = 18;              // chroma offset

  localparam longint SQ_L =
    ((64'd8660254038 << FRAC_BITS) + 64'd5000000000) / 64'd10000000000;
  localparam logic signed [TW-1:0] FX_SQ   = TW'(SQ_L);
  localparam logic signed [TW-1:0] FX_ONE  = TW'(64'd1 << FRAC_BITS);
  localparam logic signed [TW-1:0] FX_HALF = TW'(64'd1 << (FRAC_BITS - 1));
  localparam logic [SW-1:0]        RBIAS   = SW'((64'd1 << FRAC_BITS) - 64'd1);

  // configuration registers
  logic               mode_r;
  logic signed [15:0] gain_r;
  logic [15:0]        angle_r;
  logic [7:0]         white_v_r;
  logic [7:0]         white_u_r;

  logic                      cfg_wr;
  lcrs_pkg::reg_idx_t        cfg_idx;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = lcrs_pkg::reg_idx_t'(paddr[lcrs_pkg::ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= lcrs_pkg::MODE_RST;
      gain_r    <= lcrs_pkg::GAIN_RST;
      angle_r   <= lcrs_pkg::ANGLE_RST;
      white_v_r <= lcrs_pkg::WHITE_V_RST;
      white_u_r <= lcrs_pkg::WHITE_U_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        lcrs_pkg::REG_MODE:     mode_r    <= pwdata[0];
        lcrs_pkg::REG_SAT_GAIN: gain_r    <= $signed(pwdata[15:0]);
        lcrs_pkg::REG_ANGLE:    angle_r   <= pwdata[15:0];
        lcrs_pkg::REG_WHITE_V:  white_v_r <= pwdata[7:0];
        lcrs_pkg::REG_WHITE_U:  white_u_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      lcrs_pkg::REG_MODE:     prdata = {31'd0, mode_r};
      lcrs_pkg::REG_SAT_GAIN: prdata = {16'd0, gain_r};
      lcrs_pkg::REG_ANGLE:    prdata = {16'd0, angle_r};
      lcrs_pkg::REG_WHITE_V:  prdata = {24'd0, white_v_r};
      lcrs_pkg::REG_WHITE_U:  prdata = {24'd0, white_u_r};
      default:                prdata = '0;
    endcase
  end

  // stage 1: edge select, chroma offsets
  logic                 v1_r;
  logic [31:0]          px1_r;
  logic signed [8:0]    dx1_r, dy1_r;
  logic [15:0]          m1_r;
  logic signed [TW-1:0] c0_1_r, s0_1_r;
  logic signed [DW-1:0] cd1_r, sd1_r;

  logic [17:0]          t3_nxt;
  logic signed [TW-1:0] c0_nxt, s0_nxt, c1_nxt, s1_nxt;
  logic signed [8:0]    dx_nxt, dy_nxt;

  always_comb begin
    t3_nxt = {2'b00, angle_r} + {1'b0, angle_r, 1'b0};
    case (t3_nxt[17:16])
      2'd0: begin
        c0_nxt = '0;      s0_nxt = FX_ONE;
        c1_nxt = -FX_SQ;  s1_nxt = -FX_HALF;
      end
      2'd1: begin
        c0_nxt = -FX_SQ;  s0_nxt = -FX_HALF;
        c1_nxt = FX_SQ;   s1_nxt = -FX_HALF;
      end
      default: begin
        c0_nxt = FX_SQ;   s0_nxt = -FX_HALF;
        c1_nxt = '0;      s1_nxt = FX_ONE;
      end
    endcase
    dx_nxt = $signed({1'b0, in_pixel_in[7:0]}) - $signed({1'b0, white_v_r});
    dy_nxt = $signed({1'b0, in_pixel_in[15:8]}) - $signed({1'b0, white_u_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= start && !busy;
    px1_r  <= in_pixel_in;
    dx1_r  <= dx_nxt;
    dy1_r  <= dy_nxt;
    m1_r   <= t3_nxt[15:0];
    c0_1_r <= c0_nxt;
    s0_1_r <= s0_nxt;
    cd1_r  <= DW'(c1_nxt - c0_nxt);
    sd1_r  <= DW'(s1_nxt - s0_nxt);
  end

  // stage 2: interpolation and gain products
  logic                  v2_r;
  logic [31:0]           px2_r;
  logic signed [8:0]     dx2_r, dy2_r;
  logic signed [TW-1:0]  c0_2_r, s0_2_r;
  logic signed [PCW-1:0] pc2_r, ps2_r;
  logic signed [GW-1:0]  gx2_r, gy2_r;
  logic signed [MW-1:0]  m_s;

  assign m_s = $signed({1'b0, m1_r});

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
    px2_r  <= px1_r;
    dx2_r  <= dx1_r;
    dy2_r  <= dy1_r;
    c0_2_r <= c0_1_r;
    s0_2_r <= s0_1_r;
    pc2_r  <= cd1_r * m_s;
    ps2_r  <= sd1_r * m_s;
    gx2_r  <= dx1_r * gain_r;
    gy2_r  <= dy1_r * gain_r;
  end

  // stage 3: sine, cosine and scaled offsets, truncated toward zero
  logic                  v3_r;
  logic [31:0]           px3_r;
  logic signed [8:0]     dx3_r, dy3_r;
  logic signed [TW-1:0]  c3_r, s3_r;
  logic signed [OW-1:0]  ox3_r, oy3_r;

  logic signed [PCW-1:0] pc_adj, ps_adj;
  logic signed [GW-1:0]  gx_adj, gy_adj;
  logic signed [TW-1:0]  c_nxt, s_nxt;

  always_comb begin
    pc_adj = pc2_r + (pc2_r[PCW-1] ? PCW'(16'hFFFF) : PCW'(0));
    ps_adj = ps2_r + (ps2_r[PCW-1] ? PCW'(16'hFFFF) : PCW'(0));
    gx_adj = gx2_r + (gx2_r[GW-1] ? GW'(8'hFF) : GW'(0));
    gy_adj = gy2_r + (gy2_r[GW-1] ? GW'(8'hFF) : GW'(0));
    c_nxt  = c0_2_r + TW'($signed(pc_adj[16 +: DW]));
    s_nxt  = s0_2_r + TW'($signed(ps_adj[16 +: DW]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else        v3_r <= v2_r;
    px3_r <= px2_r;
    dx3_r <= dx2_r;
    dy3_r <= dy2_r;
    c3_r  <= c_nxt;
    s3_r  <= s_nxt;
    ox3_r <= OW'($signed(gx_adj[GW-1:8]));
    oy3_r <= OW'($signed(gy_adj[GW-1:8]));
  end

  // stage 4: rotation products
  logic                  v4_r;
  logic [31:0]           px4_r;
  logic signed [OW-1:0]  ox4_r, oy4_r;
  logic signed [PW-1:0]  xs4_r, yc4_r, ys4_r, xc4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else        v4_r <= v3_r;
    px4_r <= px3_r;
    ox4_r <= ox3_r;
    oy4_r <= oy3_r;
    xs4_r <= dx3_r * s3_r;
    yc4_r <= dy3_r * c3_r;
    ys4_r <= dy3_r * s3_r;
    xc4_r <= dx3_r * c3_r;
  end

  // stage 5: rotated sums, mode select, clamp
  logic                 v5_r;
  logic [31:0]          px5_r;
  logic signed [SW-1:0] rv_sum, ru_sum, rv_adj, ru_adj;
  logic signed [OW-1:0] offv, offu;
  logic signed [OW:0]   nv_full, nu_full;
  logic [7:0]           nv_nxt, nu_nxt;

  always_comb begin
    rv_sum = SW'(xs4_r) - SW'(yc4_r);
    ru_sum = SW'(ys4_r) + SW'(xc4_r);
    rv_adj = rv_sum + (rv_sum[SW-1] ? RBIAS : SW'(0));
    ru_adj = ru_sum + (ru_sum[SW-1] ? RBIAS : SW'(0));
    if (mode_r == lcrs_pkg::MODE_ROTATE) begin
      offv = OW'($signed(rv_adj[SW-1:FRAC_BITS]));
      offu = OW'($signed(ru_adj[SW-1:FRAC_BITS]));
    end else begin
      offv = ox4_r;
      offu = oy4_r;
    end
    nv_full = $signed({{(OW-7){1'b0}}, white_v_r}) + (OW+1)'(offv);
    nu_full = $signed({{(OW-7){1'b0}}, white_u_r}) + (OW+1)'(offu);
    if (nv_full[OW])             nv_nxt = 8'd0;
    else if (nv_full > 19'sd255) nv_nxt = 8'd255;
    else                         nv_nxt = nv_full[7:0];
    if (nu_full[OW])             nu_nxt = 8'd0;
    else if (nu_full > 19'sd255) nu_nxt = 8'd255;
    else                         nu_nxt = nu_full[7:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else        v5_r <= v4_r;
    px5_r <= {px4_r[31:16], nu_nxt, nv_nxt};
  end

  assign out_valid     = v5_r;
  assign out_pixel_out = px5_r;

endmodule

// File: test/chroma_checker.sv
`timescale 1ns / 1ps

module chroma_checker #(
  parameter int FRAC_BITS = lcrs_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        busy,
  input  logic [lcrs_pkg::PIX_W-1:0]  in_pixel_in,
  input  logic                        out_valid,
  input  logic [lcrs_pkg::PIX_W-1:0]  out_pixel_out,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lcrs_pkg::ADDR_W-1:0] paddr,
  input  logic [lcrs_pkg::DATA_W-1:0] pwdata,
  input  logic                        pready,
  output int                          pending,
  output int                          mismatches
);
  import lcrs_pkg::*;

  localparam longint FX_ONE  = longint'(1) << FRAC_BITS;
  localparam longint FX_HALF = longint'(1) << (FRAC_BITS - 1);
  // sqrt(3)/2 rounded to nearest at the sine/cosine scale
  localparam longint FX_SQ3H =
    longint'(((64'd8660254038 << FRAC_BITS) + 64'd5000000000) / 64'd10000000000);

  typedef struct {
    logic [PIX_W-1:0] pixel_in;
    logic [PIX_W-1:0] pixel_out;
  } chroma_req_t;

  logic               mode_q;
  logic signed [15:0] gain_q;
  logic [15:0]        angle_q;
  logic [7:0]         white_v_q;
  logic [7:0]         white_u_q;

  chroma_req_t adjusted_q[$];
  chroma_req_t oldest;

  initial begin
    pending    = 0;
    mismatches = 0;
  end

  function automatic void tri_vertex(input int k, output longint c, output longint s);
    case (k)
      0: begin
        c = 0;
        s = FX_ONE;
      end
      1: begin
        c = -FX_SQ3H;
        s = -FX_HALF;
      end
      default: begin
        c = FX_SQ3H;
        s = -FX_HALF;
      end
    endcase
  endfunction

  // walk the triangle edge picked by 3*angle, position along it is the low 16 bits
  function automatic void tri_sincos(input logic [15:0] ang, output longint c,
                                     output longint s);
    logic [17:0] t3;
    int          k;
    int          k1;
    longint      m;
    longint      c0, s0, c1, s1;
    t3 = {2'b00, ang} * 18'd3;
    k  = int'(t3[17:16]);
    k1 = (k == 2) ? 0 : k + 1;
    m  = t3[15:0];
    tri_vertex(k, c0, s0);
    tri_vertex(k1, c1, s1);
    c = c0 + ((c1 - c0) * m) / 65536;
    s = s0 + ((s1 - s0) * m) / 65536;
  endfunction

  function automatic logic [7:0] limit_byte(input longint x);
    if (x < 0) return 8'd0;
    if (x > 255) return 8'd255;
    return x[7:0];
  endfunction

  function automatic logic [PIX_W-1:0] adjust_pixel(input logic [PIX_W-1:0] px);
    longint v, u, wv, wu, dx, dy, g, c, s, nv, nu;
    v  = px[7:0];
    u  = px[15:8];
    wv = white_v_q;
    wu = white_u_q;
    g  = gain_q;
    dx = v - wv;
    dy = u - wu;
    if (mode_q == MODE_SCALE) begin
      nv = wv + (dx * g) / 256;
      nu = wu + (dy * g) / 256;
    end else begin
      tri_sincos(angle_q, c, s);
      nv = wv + (dx * s - dy * c) / FX_ONE;
      nu = wu + (dy * s + dx * c) / FX_ONE;
    end
    return {px[31:16], limit_byte(nu), limit_byte(nv)};
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      mode_q    <= MODE_RST;
      gain_q    <= GAIN_RST;
      angle_q   <= ANGLE_RST;
      white_v_q <= WHITE_V_RST;
      white_u_q <= WHITE_U_RST;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[ADDR_W-1:2]))
          REG_MODE:     mode_q    <= pwdata[0];
          REG_SAT_GAIN: gain_q    <= pwdata[15:0];
          REG_ANGLE:    angle_q   <= pwdata[15:0];
          REG_WHITE_V:  white_v_q <= pwdata[7:0];
          REG_WHITE_U:  white_u_q <= pwdata[7:0];
          default: ;
        endcase
      end
      // check before pushing: a request can never come out at its own edge
      if (out_valid) begin
        if (adjusted_q.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected pixel %h at %0t", out_pixel_out, $realtime);
          mismatches++;
        end else begin
          oldest = adjusted_q.pop_front();
          if (out_pixel_out !== oldest.pixel_out) begin
            if (mismatches < 10)
              $display("pixel_out for %h: expected %h, got %h at %0t",
                       oldest.pixel_in, oldest.pixel_out, out_pixel_out, $realtime);
            mismatches++;
          end
        end
      end
      if (start && !busy)
        adjusted_q.push_back('{pixel_in: in_pixel_in, pixel_out: adjust_pixel(in_pixel_in)});
      pending = adjusted_q.size();
    end
  end

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import lcrs_pkg::*;

  // no register decoded here, writes must be dropped
  localparam logic [IDX_W-1:0] REG_SPARE = 3'd5;
  localparam int STALL_LIMIT = 2000;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [PIX_W-1:0]  in_pixel_in;
  logic              out_valid;
  logic [PIX_W-1:0]  out_pixel_out;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int         pending;
  int         mismatches;
  int         stall_cycles = 0;
  int         send_gap_pct;
  logic [7:0] cur_wv;
  logic [7:0] cur_wu;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  luv_chroma_rotate_saturate_top u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_pixel_in   (in_pixel_in),
    .out_valid     (out_valid),
    .out_pixel_out (out_pixel_out),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  chroma_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_pixel_in   (in_pixel_in),
    .out_valid     (out_valid),
    .out_pixel_out (out_pixel_out),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .pending       (pending),
    .mismatches    (mismatches)
  );

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (psel && penable && pready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic issue_pixel(input logic [PIX_W-1:0] pix);
    logic taken;
    while ($urandom_range(99) < send_gap_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start       <= 1'b1;
    in_pixel_in <= pix;
    do begin
      @(posedge clk);
      taken = !busy;
      @(negedge clk);
    end while (!taken);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic apb_write(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // unused upper bits of each write carry noise
  task automatic program_chroma(input logic m, input logic signed [15:0] g,
                                input logic [15:0] a, input logic [7:0] wv,
                                input logic [7:0] wu);
    logic [DATA_W-1:0] d;
    drain_results();
    d = $urandom;
    d[0] = m;
    apb_write(REG_MODE, d);
    d = $urandom;
    d[15:0] = g;
    apb_write(REG_SAT_GAIN, d);
    d = $urandom;
    d[15:0] = a;
    apb_write(REG_ANGLE, d);
    d = $urandom;
    d[7:0] = wv;
    apb_write(REG_WHITE_V, d);
    d = $urandom;
    d[7:0] = wu;
    apb_write(REG_WHITE_U, d);
    cur_wv = wv;
    cur_wu = wu;
  endtask

  function automatic logic [7:0] pick_white();
    case ($urandom_range(4))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd128;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic random_setting();
    logic signed [15:0] g;
    logic [15:0]        a;
    logic [7:0]         wv;
    logic [7:0]         wu;
    case ($urandom_range(7))
      0: g = 16'sh8000;
      1: g = 16'sh7FFF;
      2: g = 16'sd256;
      3: g = 16'sd0;
      default: g = 16'(int'($urandom_range(1024)) - 512);
    endcase
    case ($urandom_range(5))
      0: a = 16'h0000;
      1: a = 16'hFFFF;
      2: a = 16'h5555;
      3: a = 16'hAAAA;
      default: a = 16'($urandom);
    endcase
    wv = pick_white();
    wu = pick_white();
    program_chroma($urandom_range(1) ? MODE_ROTATE : MODE_SCALE, g, a, wv, wu);
  endtask

  // some chroma near white so results land inside the clamp range
  function automatic logic [PIX_W-1:0] make_pixel();
    logic [PIX_W-1:0] p;
    p = $urandom;
    case ($urandom_range(3))
      0: begin
        p[15:8] = cur_wu + 8'($urandom_range(16)) - 8'd8;
        p[7:0]  = cur_wv + 8'($urandom_range(16)) - 8'd8;
      end
      1: begin
        p[15:8] = $urandom_range(1) ? 8'hFF : 8'h00;
        p[7:0]  = $urandom_range(1) ? 8'hFF : 8'h00;
      end
      default: ;
    endcase
    return p;
  endfunction

  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    in_pixel_in  = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    send_gap_pct = 0;
    cur_wv       = WHITE_V_RST;
    cur_wu       = WHITE_U_RST;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings are unity gain, pixels come back unchanged
    issue_pixel(32'h0000_0000);
    issue_pixel(32'hFFFF_FFFF);
    issue_pixel(32'h7C00_FF00);
    issue_pixel(32'hFC00_00FF);
    issue_pixel(32'h3C00_8080);
    drain_results();
    apb_write(REG_SPARE, 32'hFFFF_FFFF);
    issue_pixel(32'h1234_40C0);
    issue_pixel(32'h8001_FF01);

    // negative gain mirrors through white
    program_chroma(MODE_SCALE, -16'sd256, 16'h0000, 8'd128, 8'd128);
    issue_pixel(32'h0000_FF00);
    issue_pixel(32'h0000_00FF);
    issue_pixel(32'hABCD_2090);

    program_chroma(MODE_SCALE, 16'sh8000, 16'h0000, 8'd0, 8'd255);
    issue_pixel(32'h0000_00FF);
    issue_pixel(32'h5555_0001);
    program_chroma(MODE_SCALE, 16'sh7FFF, 16'h0000, 8'd255, 8'd0);
    issue_pixel(32'hFFFF_01FE);
    issue_pixel(32'h0000_0000);

    // rotation: zero angle, triangle vertices, last step before a full turn, quarter turn
    program_chroma(MODE_ROTATE, 16'sd256, 16'h0000, 8'd128, 8'd128);
    issue_pixel(32'h3C00_FF00);
    issue_pixel(32'h0000_20E0);
    program_chroma(MODE_ROTATE, 16'sd256, 16'h5555, 8'd128, 8'd128);
    issue_pixel(32'h0000_FF00);
    program_chroma(MODE_ROTATE, 16'sd256, 16'hAAAB, 8'd128, 8'd128);
    issue_pixel(32'h0000_00FF);
    program_chroma(MODE_ROTATE, 16'sd256, 16'hFFFF, 8'd128, 8'd128);
    issue_pixel(32'h1111_F010);
    program_chroma(MODE_ROTATE, 16'sd256, 16'h4000, 8'd128, 8'd128);
    issue_pixel(32'h0000_C040);

    for (int ph = 0; ph < 3; ph++) begin
      send_gap_pct = (ph == 0) ? 8 : (ph == 1) ? 77 : 0;
      for (int blk = 0; blk < 6; blk++) begin
        random_setting();
        repeat (45) issue_pixel(make_pixel());
      end
    end

    drain_results();
    repeat (10) @(negedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: luv_chroma_rotate_saturate_top.f
design/lcrs_pkg.sv
design/luv_chroma_rotate_saturate_top.sv
test/chroma_checker.sv
test/testbench.sv
